// ----- sv/iir_direct_form_one_assert.svh -----
// Assertion macros used by the filter top level.
`ifndef IIR_DIRECT_FORM_ONE_ASSERT_SVH
`define IIR_DIRECT_FORM_ONE_ASSERT_SVH

`ifndef ASSERT_OFF

// clocked check, held off while reset is active
`define IIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define IIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define IIR_ASSERT(lbl, prop, msg)
`define IIR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- sv/iir_df1_pkg.sv -----
// Types, widths and register codes for the direct form I filter.
package iir_df1_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CoefWidth   = 18;
  localparam int unsigned CoefFrac    = 14;
  localparam int unsigned NumTaps     = 3;
  localparam int unsigned OrderWidth  = 2;
  localparam int unsigned NumRegs     = 8;
  localparam int unsigned RegIdxWidth = $clog2(NumRegs);

  // one product, one tap term (b*x - a*y), the full sum of 2*NumTaps+1 products
  localparam int unsigned ProdWidth  = SampleWidth + CoefWidth;
  localparam int unsigned TermWidth  = ProdWidth + 1;
  localparam int unsigned AccWidth   = ProdWidth + $clog2(2 * NumTaps + 1);
  localparam int unsigned RoundWidth = AccWidth - CoefFrac;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [CoefWidth-1:0]   coef_t;
  typedef logic signed [ProdWidth-1:0]   prod_t;
  typedef logic signed [TermWidth-1:0]   term_t;
  typedef logic signed [AccWidth-1:0]    acc_t;
  typedef logic signed [RoundWidth-1:0]  round_t;
  typedef logic [OrderWidth-1:0]         order_t;

  localparam coef_t   CoefOne   = coef_t'(2 ** CoefFrac);
  localparam acc_t    RoundHalf = acc_t'(2 ** (CoefFrac - 1));
  localparam sample_t SampleMax = {1'b0, {(SampleWidth - 1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleWidth - 1){1'b0}}};

  // configuration register index
  typedef enum logic [RegIdxWidth-1:0] {
    RegOrder = 3'd0,
    RegB0    = 3'd1,
    RegB1    = 3'd2,
    RegB2    = 3'd3,
    RegB3    = 3'd4,
    RegA1    = 3'd5,
    RegA2    = 3'd6,
    RegA3    = 3'd7
  } reg_idx_e;

  // coefficient write into one tap cell
  typedef struct packed {
    logic  b_we;
    logic  a_we;
    coef_t data;
  } coef_wr_t;

endpackage

// ----- sv/iir_df1_tap_cell.sv -----
// One lag of the filter: coefficient pair, input/output history and tap term.
module iir_df1_tap_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  en_i,
  input  iir_df1_pkg::coef_wr_t coef_wr_i,
  input  iir_df1_pkg::sample_t  x_i,
  input  iir_df1_pkg::sample_t  y_i,
  output iir_df1_pkg::sample_t  x_o,
  output iir_df1_pkg::sample_t  y_o,
  output iir_df1_pkg::term_t    term_o
);
  import iir_df1_pkg::*;

  coef_t   b_q, a_q;
  sample_t x_q, y_q;
  prod_t   bx, ay;

  // coefficient pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
      a_q <= '0;
    end else begin
      if (coef_wr_i.b_we) begin
        b_q <= coef_wr_i.data;
      end
      if (coef_wr_i.a_we) begin
        a_q <= coef_wr_i.data;
      end
    end
  end

  // history words move one cell down on every accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (shift_i) begin
      x_q <= x_i;
      y_q <= y_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

  // b*x[n-k] - a*y[n-k], zero when the lag is beyond the order
  assign bx     = prod_t'(b_q) * prod_t'(x_q);
  assign ay     = prod_t'(a_q) * prod_t'(y_q);
  assign term_o = en_i ? (term_t'(bx) - term_t'(ay)) : '0;

endmodule

// ----- sv/iir_df1_out_stage.sv -----
// Rounding, saturation and the output register.
module iir_df1_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iir_df1_pkg::acc_t    acc_i,
  input  logic                 load_i,
  input  logic                 ready_i,
  output iir_df1_pkg::sample_t y_o,
  output logic                 valid_o,
  output iir_df1_pkg::sample_t sample_o,
  output logic                 sat_o
);
  import iir_df1_pkg::*;

  acc_t    acc_rnd;
  round_t  y_wide;
  logic    over, under;
  logic    valid_d, valid_q;
  sample_t sample_q;
  logic    sat_q;

  // round half up, floor by dropping the fraction bits
  assign acc_rnd = acc_i + RoundHalf;
  assign y_wide  = acc_rnd[AccWidth-1:CoefFrac];

  // clip to the sample range
  assign over  = y_wide > round_t'(SampleMax);
  assign under = y_wide < round_t'(SampleMin);
  assign y_o   = over  ? SampleMax :
                 under ? SampleMin : y_wide[SampleWidth-1:0];

  // output word register
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= y_o;
      sat_q    <= over | under;
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;
  assign sat_o    = sat_q;

endmodule

// ----- sv/iir_direct_form_one.sv -----
// Direct form I IIR filter, top level.
// Takes one signed 16-bit sample per cycle unless an untaken output word waits,
// and outputs its filtered word next cycle; throughput is bounded by the feedback
// loop from the newest output through the a1 product, the sum, rounding and
// saturation back into the first history cell. Coefficients are signed Q3.14;
// the exact sum is rounded half up and clipped to 16 bits, and saturated_o flags
// a clipped word. Histories reset to zero, b0 to 1.0, all other coefficients and
// the order to zero. Write configuration only while no word is in flight.
module iir_direct_form_one (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [iir_df1_pkg::RegIdxWidth-1:0]  cfg_idx_i,
  input  logic [iir_df1_pkg::CoefWidth-1:0]    cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [iir_df1_pkg::SampleWidth-1:0] sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [iir_df1_pkg::SampleWidth-1:0] sample_out_o,
  output logic                                 saturated_o
);
  import iir_df1_pkg::*;

`include "iir_direct_form_one_assert.svh"

  order_t   order_q;
  coef_t    b0_q;
  coef_wr_t coef_wr [NumTaps];
  sample_t  x_hist [NumTaps];
  sample_t  y_hist [NumTaps];
  term_t    term [NumTaps];
  logic     tap_en [NumTaps];
  prod_t    b0x;
  acc_t     acc;
  sample_t  y_new;
  logic     in_acc;

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // order and b0 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
      b0_q    <= CoefOne;
    end else if (cfg_we_i) begin
      if (reg_idx_e'(cfg_idx_i) == RegOrder) begin
        order_q <= cfg_wdata_i[OrderWidth-1:0];
      end
      if (reg_idx_e'(cfg_idx_i) == RegB0) begin
        b0_q <= cfg_wdata_i;
      end
    end
  end

  // lag coefficient write decode
  always_comb begin
    for (int k = 0; k < NumTaps; k++) begin
      coef_wr[k].b_we = 1'b0;
      coef_wr[k].a_we = 1'b0;
      coef_wr[k].data = cfg_wdata_i;
    end
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegB1:   coef_wr[0].b_we = 1'b1;
        RegB2:   coef_wr[1].b_we = 1'b1;
        RegB3:   coef_wr[2].b_we = 1'b1;
        RegA1:   coef_wr[0].a_we = 1'b1;
        RegA2:   coef_wr[1].a_we = 1'b1;
        RegA3:   coef_wr[2].a_we = 1'b1;
        default: ;
      endcase
    end
  end

  // row of tap cells, histories handed down the row
  for (genvar k = 0; k < NumTaps; k++) begin : g_tap
    assign tap_en[k] = order_q > order_t'(k);
    if (k == 0) begin : g_first
      iir_df1_tap_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (in_acc),
        .en_i      (tap_en[k]),
        .coef_wr_i (coef_wr[k]),
        .x_i       (sample_in_i),
        .y_i       (y_new),
        .x_o       (x_hist[k]),
        .y_o       (y_hist[k]),
        .term_o    (term[k])
      );
    end else begin : g_next
      iir_df1_tap_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (in_acc),
        .en_i      (tap_en[k]),
        .coef_wr_i (coef_wr[k]),
        .x_i       (x_hist[k-1]),
        .y_i       (y_hist[k-1]),
        .x_o       (x_hist[k]),
        .y_o       (y_hist[k]),
        .term_o    (term[k])
      );
    end
  end

  // b0*x plus the tap terms
  assign b0x = prod_t'(b0_q) * prod_t'(sample_in_i);

  always_comb begin
    acc = acc_t'(b0x);
    for (int k = 0; k < NumTaps; k++) begin
      acc = acc + acc_t'(term[k]);
    end
  end

  iir_df1_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .load_i   (in_acc),
    .ready_i  (out_ready_i),
    .y_o      (y_new),
    .valid_o  (out_valid_o),
    .sample_o (sample_out_o),
    .sat_o    (saturated_o)
  );

  // checks
  `IIR_ASSERT(a_result_follows, in_acc |=> out_valid_o, "accepted sample gave no output word")
  `IIR_ASSERT(a_feedback_matches, in_acc |=> (y_hist[0] == sample_out_o),
              "output history does not hold the delivered word")
  `IIR_ASSERT(a_sat_clips, (out_valid_o && saturated_o) |->
              (sample_out_o == SampleMax || sample_out_o == SampleMin),
              "saturated word is not at a range limit")
  `IIR_ASSERT(a_hist_hold, !in_acc |=> ($stable(x_hist[0]) && $stable(y_hist[0])),
              "history moved without an accepted sample")

endmodule

// ----- tb/sv/tb_iir_direct_form_one.sv -----
// Self-checking testbench for the direct form I IIR filter.
module tb_iir_direct_form_one;
  timeunit 1ns;
  timeprecision 1ps;

  import iir_df1_pkg::*;

  localparam coef_t CoefMax      = {1'b0, {(CoefWidth - 1){1'b1}}};
  localparam coef_t CoefMin      = {1'b1, {(CoefWidth - 1){1'b0}}};
  localparam int    HoldCycles   = 200;
  localparam int    SettleCycles = 4;
  localparam int    CycleLimit   = 400000;

  typedef struct packed {
    sample_t value;
    logic    sat;
  } out_word_t;

  typedef enum logic {RxAlways, RxBursty} rx_mode_e;
  typedef enum logic [2:0] {CfgStable, CfgFull, CfgAllMax, CfgAllMin, CfgFir} cfg_kind_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [RegIdxWidth-1:0] cfg_idx_i;
  logic [CoefWidth-1:0]   cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  sample_t                sample_in_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  sample_t                sample_out_o;
  logic                   saturated_o;

  // filter state mirrored by the predictor
  order_t  flt_order;
  coef_t   gain_b0;
  coef_t   ff_coef [NumTaps];
  coef_t   fb_coef [NumTaps];
  sample_t past_in [NumTaps];
  sample_t past_out[NumTaps];

  out_word_t pending_words[$];
  int        err_count   = 0;
  int        cycle_count = 0;

  // receiver controls: mode and hold requests come from the tests
  rx_mode_e rx_mode      = RxAlways;
  int       rx_hold_req  = 0;
  int       rx_hold_seen = 0;
  int       rx_hold_left = 0;
  int       rx_run       = 0;
  logic     rx_stalling  = 1'b0;

  iir_direct_form_one dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o),
    .saturated_o (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // next filtered word; shifts both histories as the filter does
  function automatic out_word_t filter_next_sample(input sample_t x);
    longint    acc;
    longint    rounded;
    int        lags;
    out_word_t w;
    lags = (flt_order > NumTaps) ? NumTaps : int'(flt_order);
    acc  = longint'(gain_b0) * longint'(x);
    for (int k = 0; k < lags; k++) begin
      acc += longint'(ff_coef[k]) * longint'(past_in[k]);
      acc -= longint'(fb_coef[k]) * longint'(past_out[k]);
    end
    // arithmetic shift gives floor, so ties go up
    rounded = (acc + longint'(RoundHalf)) >>> CoefFrac;
    w.sat   = 1'b0;
    if (rounded > longint'(SampleMax)) begin
      w.value = SampleMax;
      w.sat   = 1'b1;
    end else if (rounded < longint'(SampleMin)) begin
      w.value = SampleMin;
      w.sat   = 1'b1;
    end else begin
      w.value = sample_t'(rounded);
    end
    for (int k = NumTaps - 1; k > 0; k--) begin
      past_in[k]  = past_in[k-1];
      past_out[k] = past_out[k-1];
    end
    past_in[0]  = x;
    past_out[0] = w.value;
    return w;
  endfunction

  // register writes, accepted inputs and output checks, all at the clock edge
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegOrder: flt_order  = cfg_wdata_i[OrderWidth-1:0];
          RegB0:    gain_b0    = coef_t'(cfg_wdata_i);
          RegB1:    ff_coef[0] = coef_t'(cfg_wdata_i);
          RegB2:    ff_coef[1] = coef_t'(cfg_wdata_i);
          RegB3:    ff_coef[2] = coef_t'(cfg_wdata_i);
          RegA1:    fb_coef[0] = coef_t'(cfg_wdata_i);
          RegA2:    fb_coef[1] = coef_t'(cfg_wdata_i);
          RegA3:    fb_coef[2] = coef_t'(cfg_wdata_i);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        pending_words = {pending_words, filter_next_sample(sample_in_i)};
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_words.size() == 0) begin
          err_count++;
          $display("%0t: output word with none expected, sample_out=%0d saturated=%0b",
                   $time, sample_out_o, saturated_o);
        end else begin
          want = pending_words.pop_front();
          if (sample_out_o !== want.value) begin
            err_count++;
            $display("%0t: sample_out expected %0d actual %0d",
                     $time, want.value, sample_out_o);
          end
          if (saturated_o !== want.sat) begin
            err_count++;
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.sat, saturated_o);
          end
        end
      end
    end
  end

  // receiver: long holds on request, else steady ready or ready and stall runs
  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = HoldCycles;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_mode == RxAlways) begin
      out_ready_i <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_stalling = ($urandom_range(0, 2) == 0);
        rx_run      = rx_stalling ? $urandom_range(1, 6) : $urandom_range(1, 12);
      end
      rx_run--;
      out_ready_i <= !rx_stalling;
    end
  end

  // offer one word and hold it until taken
  task automatic send_sample(input sample_t x);
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop offering, wait for every expected word, then let the pipe settle
  task automatic drain_filter();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all registers; order word carries random upper bits
  task automatic program_filter(input order_t ord,
                                input coef_t b0, b1, b2, b3, a1, a2, a3);
    logic [CoefWidth-1:0] word [NumRegs];
    word[RegOrder] = CoefWidth'($urandom);
    word[RegOrder][OrderWidth-1:0] = ord;
    word[RegB0] = b0;
    word[RegB1] = b1;
    word[RegB2] = b2;
    word[RegB3] = b3;
    word[RegA1] = a1;
    word[RegA2] = a2;
    word[RegA3] = a3;
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= RegIdxWidth'(i);
      cfg_wdata_i <= word[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0:       s = SampleMax;
      1:       s = SampleMin;
      2, 3, 4: s = sample_t'(int'($urandom_range(0, 512)) - 256);
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  function automatic coef_t rand_coef(input cfg_kind_e kind, input logic feedback);
    coef_t c;
    case (kind)
      CfgAllMax: c = CoefMax;
      CfgAllMin: c = CoefMin;
      CfgFull:   c = coef_t'($urandom);
      CfgFir:    c = feedback ? coef_t'(0)
                              : coef_t'(int'($urandom_range(0, 2 * CoefOne)) - CoefOne);
      default:   c = feedback ? coef_t'(int'($urandom_range(0, 8192)) - 4096)
                              : coef_t'(int'($urandom_range(0, 16384)) - 8192);
    endcase
    return c;
  endfunction

  // bursts of random length with random gaps between them
  task automatic run_stream(input int count, input int max_gap);
    int burst;
    int gap;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        gap   = $urandom_range(0, max_gap);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      send_sample(rand_sample());
      burst--;
    end
  endtask

  // reset configuration: order zero, unity gain, so words pass through
  task automatic test_reset_gain();
    rx_mode = RxBursty;
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(sample_t'(0));
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'hAAAA));
    drain_filter();
  endtask

  // half gain puts odd inputs exactly on a rounding tie, positive and negative
  task automatic test_rounding();
    program_filter(order_t'(0), coef_t'(CoefOne / 2), '0, '0, '0, '0, '0, '0);
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(3));
    send_sample(sample_t'(-3));
    drain_filter();
  endtask

  // clipping both ways; clipped words must feed back as clipped
  task automatic test_saturation();
    program_filter('1, CoefMax, CoefMax, CoefMax, CoefMax, CoefMin, CoefMin, CoefMin);
    send_sample(SampleMax);
    send_sample(SampleMax);
    send_sample(SampleMin);
    drain_filter();
    program_filter(order_t'(0), CoefMin, '0, '0, '0, '0, '0, '0);
    send_sample(SampleMin);
    send_sample(SampleMax);
    drain_filter();
  endtask

  // histories keep shifting at order zero and are used once the order rises
  task automatic test_order_change();
    program_filter(order_t'(0), CoefOne, CoefOne, coef_t'(-CoefOne), CoefOne,
                   coef_t'(-8192), coef_t'(4096), coef_t'(2048));
    send_sample(sample_t'(1000));
    send_sample(sample_t'(-2000));
    send_sample(sample_t'(3000));
    drain_filter();
    program_filter('1, CoefOne, CoefOne, coef_t'(-CoefOne), CoefOne,
                   coef_t'(-8192), coef_t'(4096), coef_t'(2048));
    send_sample(sample_t'(400));
    send_sample(sample_t'(-500));
    send_sample(sample_t'(600));
    drain_filter();
  endtask

  // long receiver hold while the sender keeps offering back to back
  task automatic test_backpressure();
    program_filter(order_t'(2), rand_coef(CfgStable, 1'b0), rand_coef(CfgStable, 1'b0),
                   rand_coef(CfgStable, 1'b0), rand_coef(CfgStable, 1'b0),
                   rand_coef(CfgStable, 1'b1), rand_coef(CfgStable, 1'b1),
                   rand_coef(CfgStable, 1'b1));
    rx_mode = RxBursty;
    rx_hold_req++;
    run_stream(48, 0);
    drain_filter();
  endtask

  // random configurations, each followed by a random stream
  task automatic test_random_phases();
    cfg_kind_e kind;
    order_t    ord;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0)      kind = CfgAllMax;
      else if (phase == 1) kind = CfgAllMin;
      else                 kind = cfg_kind_e'($urandom_range(0, 4));
      if (phase < 2)       ord = '1;
      else if (phase < 6)  ord = order_t'(phase - 2);
      else                 ord = order_t'($urandom);
      program_filter(ord, rand_coef(kind, 1'b0), rand_coef(kind, 1'b0),
                     rand_coef(kind, 1'b0), rand_coef(kind, 1'b0),
                     rand_coef(kind, 1'b1), rand_coef(kind, 1'b1), rand_coef(kind, 1'b1));
      rx_mode = phase[0] ? RxAlways : RxBursty;
      run_stream($urandom_range(80, 110), $urandom_range(0, 1) ? 0 : 8);
      drain_filter();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    out_ready_i = 1'b0;
    // predictor starts from the reset state
    flt_order = '0;
    gain_b0   = CoefOne;
    for (int k = 0; k < NumTaps; k++) begin
      ff_coef[k]  = '0;
      fb_coef[k]  = '0;
      past_in[k]  = '0;
      past_out[k] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_gain();
    test_rounding();
    test_saturation();
    test_order_change();
    test_backpressure();
    test_random_phases();

    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- iir_direct_form_one.f -----
+incdir+sv
sv/iir_df1_pkg.sv
sv/iir_df1_tap_cell.sv
sv/iir_df1_out_stage.sv
sv/iir_direct_form_one.sv
tb/sv/tb_iir_direct_form_one.sv
